### design/bd_pkg.sv
// shared constants, types and the arctangent table for the bearing and distance block
`timescale 1ns / 1ps
`default_nettype none
package bd_pkg;

    localparam int COORD_BITS    = 16;
    localparam int CORDIC_STAGES = 16;

    localparam int HD_W      = 17;
    localparam int BEARING_W = 16;
    localparam int DIST_W    = 17;

    // coordinate difference, cordic datapath with 16 fraction bits and growth margin
    localparam int D_W       = COORD_BITS + 1;
    localparam int XY_FRAC_W = 16;
    localparam int XY_W      = D_W + XY_FRAC_W + 3;

    // fine angle in 2^-15 degree
    localparam int ANG_W   = 26;
    localparam int V_W     = 27;
    localparam int A_W     = 24;
    localparam int SHIFT_W = 5;
    localparam int OUT_SH  = 8;

    localparam int FINE_PER_DEG = 32768;
    localparam int FULL_FINE    = 360 * FINE_PER_DEG;
    localparam int QUARTER_FINE = (180 / 2) * FINE_PER_DEG;
    localparam int OUT_FULL     = 360 * (FINE_PER_DEG / (1 << OUT_SH));

    localparam logic signed [V_W-1:0] FULL_V = V_W'(FULL_FINE);

    localparam int          GAIN_W   = 24;
    localparam logic [GAIN_W-1:0] GAIN_Q24 = GAIN_W'(10188014);
    localparam int          ROUND_SH = 24;

    localparam int MHI_W = XY_W - XY_FRAC_W + GAIN_W;
    localparam int MLO_W = XY_FRAC_W + GAIN_W;
    localparam int T_W   = (MHI_W + 1 > ROUND_SH + DIST_W) ? MHI_W + 1 : ROUND_SH + DIST_W;

    typedef struct packed {
        logic signed [XY_W-1:0]  x;
        logic signed [XY_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
        logic signed [HD_W-1:0]  hd;
        logic                    zero;
    } t_cordic;

    // atan(2^-s) in fine angle units, rounded
    function automatic logic signed [ANG_W-1:0] atan_fine(input logic [SHIFT_W-1:0] s);
        case (s)
            0:       return ANG_W'(1474560);
            1:       return ANG_W'(870484);
            2:       return ANG_W'(459940);
            3:       return ANG_W'(233473);
            4:       return ANG_W'(117189);
            5:       return ANG_W'(58652);
            6:       return ANG_W'(29333);
            7:       return ANG_W'(14667);
            8:       return ANG_W'(7334);
            9:       return ANG_W'(3667);
            10:      return ANG_W'(1833);
            11:      return ANG_W'(917);
            12:      return ANG_W'(458);
            13:      return ANG_W'(229);
            14:      return ANG_W'(115);
            15:      return ANG_W'(57);
            16:      return ANG_W'(29);
            17:      return ANG_W'(14);
            18:      return ANG_W'(7);
            19:      return ANG_W'(4);
            20:      return ANG_W'(2);
            21:      return ANG_W'(1);
            default: return '0;
        endcase
    endfunction

endpackage
`default_nettype wire

### design/bd_in_if.sv
// input channel: robot pose and target point
`timescale 1ns / 1ps
`default_nettype none
interface bd_in_if;
    logic                                valid;
    logic                                ready;
    logic signed [bd_pkg::COORD_BITS-1:0] from_x;
    logic signed [bd_pkg::COORD_BITS-1:0] from_y;
    logic signed [bd_pkg::HD_W-1:0]       robot_heading;
    logic signed [bd_pkg::COORD_BITS-1:0] to_x;
    logic signed [bd_pkg::COORD_BITS-1:0] to_y;

    modport source (output valid, output from_x, output from_y, output robot_heading,
                    output to_x, output to_y, input ready);
    modport sink (input valid, input from_x, input from_y, input robot_heading,
                  input to_x, input to_y, output ready);
endinterface
`default_nettype wire

### design/bd_out_if.sv
// output channel: bearing and distance
`timescale 1ns / 1ps
`default_nettype none
interface bd_out_if;
    logic                           valid;
    logic                           ready;
    logic [bd_pkg::BEARING_W-1:0]   bearing;
    logic [bd_pkg::DIST_W-1:0]      distance;

    modport source (output valid, output bearing, output distance, input ready);
    modport sink (input valid, input bearing, input distance, output ready);
endinterface
`default_nettype wire

### design/bd_pre.sv
// input stage: coordinate differences and quarter-turn prerotation
`timescale 1ns / 1ps
`default_nettype none
module bd_pre (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic signed [bd_pkg::COORD_BITS-1:0] i_from_x,
    input  logic signed [bd_pkg::COORD_BITS-1:0] i_from_y,
    input  logic signed [bd_pkg::HD_W-1:0]       i_robot_heading,
    input  logic signed [bd_pkg::COORD_BITS-1:0] i_to_x,
    input  logic signed [bd_pkg::COORD_BITS-1:0] i_to_y,
    output logic                                o_valid,
    input  logic                                i_ready,
    output bd_pkg::t_cordic                     o_data
);
    localparam int EXT_W = bd_pkg::XY_W - bd_pkg::D_W - bd_pkg::XY_FRAC_W;

    logic signed [bd_pkg::D_W-1:0]   dx;
    logic signed [bd_pkg::D_W-1:0]   dy;
    logic signed [bd_pkg::XY_W-1:0]  x0;
    logic signed [bd_pkg::XY_W-1:0]  y0;
    bd_pkg::t_cordic                 n_data;
    bd_pkg::t_cordic                 r_data;
    logic                            r_valid;

    always_comb begin
        dx = {i_to_x[bd_pkg::COORD_BITS-1], i_to_x} - {i_from_x[bd_pkg::COORD_BITS-1], i_from_x};
        dy = {i_to_y[bd_pkg::COORD_BITS-1], i_to_y} - {i_from_y[bd_pkg::COORD_BITS-1], i_from_y};
        // cordic works on the vector (dy, dx)
        x0 = {{EXT_W{dy[bd_pkg::D_W-1]}}, dy, {bd_pkg::XY_FRAC_W{1'b0}}};
        y0 = {{EXT_W{dx[bd_pkg::D_W-1]}}, dx, {bd_pkg::XY_FRAC_W{1'b0}}};
        n_data.hd   = i_robot_heading;
        n_data.zero = (dx == '0) && (dy == '0);
        n_data.x    = x0;
        n_data.y    = y0;
        n_data.z    = '0;
        // left half plane: turn a quarter into the right half plane
        if (x0[bd_pkg::XY_W-1]) begin
            if (!y0[bd_pkg::XY_W-1]) begin
                n_data.x = y0;
                n_data.y = -x0;
                n_data.z = bd_pkg::ANG_W'(bd_pkg::QUARTER_FINE);
            end else begin
                n_data.x = -y0;
                n_data.y = x0;
                n_data.z = -bd_pkg::ANG_W'(bd_pkg::QUARTER_FINE);
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### design/bd_cordic_cell.sv
// one vectoring cordic micro-rotation with its own pipeline register
`timescale 1ns / 1ps
`default_nettype none
module bd_cordic_cell (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [bd_pkg::SHIFT_W-1:0]    i_shift,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bd_pkg::t_cordic               i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output bd_pkg::t_cordic               o_data
);
    logic signed [bd_pkg::XY_W-1:0]  xs;
    logic signed [bd_pkg::XY_W-1:0]  ys;
    logic signed [bd_pkg::ANG_W-1:0] w;
    bd_pkg::t_cordic                 n_data;
    bd_pkg::t_cordic                 r_data;
    logic                            r_valid;

    always_comb begin
        // arithmetic shift rounds toward minus infinity
        xs = $signed(i_data.x) >>> i_shift;
        ys = $signed(i_data.y) >>> i_shift;
        w  = bd_pkg::atan_fine(i_shift);
        n_data = i_data;
        if (!i_data.y[bd_pkg::XY_W-1]) begin
            n_data.x = i_data.x + ys;
            n_data.y = i_data.y - xs;
            n_data.z = i_data.z + w;
        end else begin
            n_data.x = i_data.x - ys;
            n_data.y = i_data.y + xs;
            n_data.z = i_data.z - w;
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;
endmodule
`default_nettype wire

### design/bd_post.sv
// gain correction, heading subtraction, angle wrap and output register
`timescale 1ns / 1ps
`default_nettype none
module bd_post (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  bd_pkg::t_cordic               i_data,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [bd_pkg::BEARING_W-1:0]  o_bearing,
    output logic [bd_pkg::DIST_W-1:0]     o_distance
);
    localparam int HEXT_W = bd_pkg::V_W - bd_pkg::HD_W - bd_pkg::OUT_SH;
    localparam int ZEXT_W = bd_pkg::V_W - bd_pkg::ANG_W;
    localparam int B_W    = bd_pkg::A_W + 1 - bd_pkg::OUT_SH;

    logic r_v1, r_v2, r_v3, r_v4;
    logic rdy1, rdy2, rdy3, rdy4;

    logic [bd_pkg::XY_W-1:0]         ux;
    logic signed [bd_pkg::ANG_W-1:0] ze;
    logic signed [bd_pkg::V_W-1:0]   hfine;
    logic [bd_pkg::MHI_W-1:0]        n1_mhi, r1_mhi;
    logic [bd_pkg::MLO_W-1:0]        n1_mlo, r1_mlo;
    logic signed [bd_pkg::V_W-1:0]   n1_v, r1_v;

    logic [bd_pkg::T_W-1:0]          n2_t, r2_t;
    logic signed [bd_pkg::V_W-1:0]   n2_v, r2_v;

    logic [bd_pkg::T_W-1:0]          rsum;
    logic signed [bd_pkg::V_W-1:0]   v3;
    logic [bd_pkg::DIST_W-1:0]       n3_dist, r3_dist;
    logic [bd_pkg::A_W-1:0]          n3_a, r3_a;

    logic [bd_pkg::A_W:0]            bsum;
    logic [B_W-1:0]                  b;
    logic [bd_pkg::BEARING_W-1:0]    n4_bearing, r4_bearing;
    logic [bd_pkg::DIST_W-1:0]       r4_dist;

    // ready chain, each register moves when empty or when its successor moves
    assign rdy4    = !r_v4 || i_ready;
    assign rdy3    = !r_v3 || rdy4;
    assign rdy2    = !r_v2 || rdy3;
    assign rdy1    = !r_v1 || rdy2;
    assign o_ready = rdy1;

    // stage 1: split gain multiply, heading subtraction
    always_comb begin
        ux     = (i_data.x[bd_pkg::XY_W-1] || i_data.zero) ? '0 : i_data.x;
        n1_mhi = bd_pkg::MHI_W'(ux[bd_pkg::XY_W-1:bd_pkg::XY_FRAC_W])
                 * bd_pkg::MHI_W'(bd_pkg::GAIN_Q24);
        n1_mlo = bd_pkg::MLO_W'(ux[bd_pkg::XY_FRAC_W-1:0]) * bd_pkg::MLO_W'(bd_pkg::GAIN_Q24);
        ze     = i_data.zero ? '0 : i_data.z;
        hfine  = {{HEXT_W{i_data.hd[bd_pkg::HD_W-1]}}, i_data.hd, {bd_pkg::OUT_SH{1'b0}}};
        n1_v   = {{ZEXT_W{ze[bd_pkg::ANG_W-1]}}, ze} - hfine;
    end

    // stage 2: sum partial products, first wrap step
    always_comb begin
        n2_t = bd_pkg::T_W'(r1_mhi) + bd_pkg::T_W'(r1_mlo[bd_pkg::MLO_W-1:bd_pkg::XY_FRAC_W]);
        n2_v = r1_v[bd_pkg::V_W-1] ? r1_v + bd_pkg::FULL_V : r1_v;
    end

    // stage 3: round distance, second wrap step lands in one full turn
    always_comb begin
        rsum    = r2_t + bd_pkg::T_W'(1 << (bd_pkg::ROUND_SH - 1));
        n3_dist = rsum[bd_pkg::ROUND_SH +: bd_pkg::DIST_W];
        if (r2_v[bd_pkg::V_W-1]) begin
            v3 = r2_v + bd_pkg::FULL_V;
        end else if (r2_v >= bd_pkg::FULL_V) begin
            v3 = r2_v - bd_pkg::FULL_V;
        end else begin
            v3 = r2_v;
        end
        n3_a = v3[bd_pkg::A_W-1:0];
    end

    // stage 4: round to output units, full turn rounds back to zero
    always_comb begin
        bsum = {1'b0, r3_a} + (bd_pkg::A_W + 1)'(1 << (bd_pkg::OUT_SH - 1));
        b    = bsum[bd_pkg::A_W:bd_pkg::OUT_SH];
        if (b >= B_W'(bd_pkg::OUT_FULL)) begin
            n4_bearing = bd_pkg::BEARING_W'(b - B_W'(bd_pkg::OUT_FULL));
        end else begin
            n4_bearing = bd_pkg::BEARING_W'(b);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (rdy1) begin
                r_v1 <= i_valid;
            end
            if (rdy2) begin
                r_v2 <= r_v1;
            end
            if (rdy3) begin
                r_v3 <= r_v2;
            end
            if (rdy4) begin
                r_v4 <= r_v3;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rdy1 && i_valid) begin
            r1_mhi <= n1_mhi;
            r1_mlo <= n1_mlo;
            r1_v   <= n1_v;
        end
        if (rdy2 && r_v1) begin
            r2_t <= n2_t;
            r2_v <= n2_v;
        end
        if (rdy3 && r_v2) begin
            r3_dist <= n3_dist;
            r3_a    <= n3_a;
        end
        if (rdy4 && r_v3) begin
            r4_bearing <= n4_bearing;
            r4_dist    <= r3_dist;
        end
    end

    assign o_valid    = r_v4;
    assign o_bearing  = r4_bearing;
    assign o_distance = r4_dist;
endmodule
`default_nettype wire

### design/bearing_and_distance.sv
// top level: body-relative bearing and distance to a target point
// an item passes the input register, the cordic cell registers, then the post registers
// one item per cycle unless stalled; each cordic cell and post stage is a register stage
// each stage moves when empty or when its successor moves, so bubbles absorb output stalls
// reset: synchronous active low, clears the stage valid bits only; no clearing pass
`timescale 1ns / 1ps
`default_nettype none
module bearing_and_distance (
    input  logic      i_clk,
    input  logic      i_rst_n,
    bd_in_if.sink     i_req,
    bd_out_if.source  o_rsp
);
    bd_pkg::t_cordic                   c_data  [0:bd_pkg::CORDIC_STAGES];
    logic [bd_pkg::CORDIC_STAGES:0]    c_valid;
    logic [bd_pkg::CORDIC_STAGES:0]    c_ready;

    bd_pre u_pre (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_valid         (i_req.valid),
        .o_ready         (i_req.ready),
        .i_from_x        (i_req.from_x),
        .i_from_y        (i_req.from_y),
        .i_robot_heading (i_req.robot_heading),
        .i_to_x          (i_req.to_x),
        .i_to_y          (i_req.to_y),
        .o_valid         (c_valid[0]),
        .i_ready         (c_ready[0]),
        .o_data          (c_data[0])
    );

    for (genvar k = 0; k < bd_pkg::CORDIC_STAGES; k++) begin : g_cell
        bd_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_shift (bd_pkg::SHIFT_W'(k)),
            .i_valid (c_valid[k]),
            .o_ready (c_ready[k]),
            .i_data  (c_data[k]),
            .o_valid (c_valid[k+1]),
            .i_ready (c_ready[k+1]),
            .o_data  (c_data[k+1])
        );
    end

    bd_post u_post (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (c_valid[bd_pkg::CORDIC_STAGES]),
        .o_ready    (c_ready[bd_pkg::CORDIC_STAGES]),
        .i_data     (c_data[bd_pkg::CORDIC_STAGES]),
        .o_valid    (o_rsp.valid),
        .i_ready    (o_rsp.ready),
        .o_bearing  (o_rsp.bearing),
        .o_distance (o_rsp.distance)
    );
endmodule
`default_nettype wire

### design/bd_checker.sv
// port-level checks for the bearing and distance block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module bd_checker (
    input logic                         i_clk,
    input logic                         i_rst_n,
    input logic                         i_in_ready,
    input logic                         i_out_valid,
    input logic                         i_out_ready,
    input logic [bd_pkg::BEARING_W-1:0] i_bearing,
    input logic [bd_pkg::DIST_W-1:0]    i_distance
);
    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_bearing) && $stable(i_distance))
        else $error("result changed while stalled");

    a_bearing_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_bearing < bd_pkg::BEARING_W'(bd_pkg::OUT_FULL))
        else $error("bearing outside one full turn");

    // with the output side taking, no stage can be stalled
    a_ready_through: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_ready |-> i_in_ready)
        else $error("input stalled while output side is ready");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");
endmodule

bind bearing_and_distance bd_checker u_bd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_ready  (i_req.ready),
    .i_out_valid (o_rsp.valid),
    .i_out_ready (o_rsp.ready),
    .i_bearing   (o_rsp.bearing),
    .i_distance  (o_rsp.distance)
);
`default_nettype wire

### test/tb_bearing_and_distance.sv
// testbench for bearing_and_distance: directed and random transfers checked by a scoreboard
`timescale 1ns / 1ps
module tb_bearing_and_distance;

    typedef struct packed {
        logic signed [bd_pkg::COORD_BITS-1:0] from_x;
        logic signed [bd_pkg::COORD_BITS-1:0] from_y;
        logic signed [bd_pkg::HD_W-1:0]       heading;
        logic signed [bd_pkg::COORD_BITS-1:0] to_x;
        logic signed [bd_pkg::COORD_BITS-1:0] to_y;
    } t_pose_req;

    typedef struct packed {
        logic [bd_pkg::BEARING_W-1:0] bearing;
        logic [bd_pkg::DIST_W-1:0]    distance;
    } t_nav_result;

    // atan(2^-i) in 2^-15 degree
    localparam longint STAGE_ANGLE [0:15] = '{
        1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
        7334, 3667, 1833, 917, 458, 229, 115, 57
    };
    localparam longint FINE_FULL    = 360 * 32768;
    localparam longint FINE_QUARTER = 90 * 32768;
    localparam longint BEARING_FULL = 360 * 128;
    localparam longint unsigned GAIN_FIX = 64'd10188014;

    class bearing_scoreboard;
        t_nav_result expected_q[$];
        int          errors;
        int          accepted;
        int          checked;

        function new();
            errors   = 0;
            accepted = 0;
            checked  = 0;
        endfunction

        function t_nav_result predict(t_pose_req r);
            longint          dx, dy, x, y, z, xs, ys, tmp, a, b;
            longint unsigned ux, prod, dist_val;
            t_nav_result     res;
            dx       = longint'(r.to_x) - longint'(r.from_x);
            dy       = longint'(r.to_y) - longint'(r.from_y);
            z        = 0;
            dist_val = 0;
            if (dx != 0 || dy != 0) begin
                x = dy * 65536;
                y = dx * 65536;
                // left half plane: quarter turn first
                if (x < 0) begin
                    tmp = x;
                    if (y >= 0) begin
                        x = y;
                        y = -tmp;
                        z = FINE_QUARTER;
                    end else begin
                        x = -y;
                        y = tmp;
                        z = -FINE_QUARTER;
                    end
                end
                for (int i = 0; i < 16; i++) begin
                    xs = x >>> i;
                    ys = y >>> i;
                    if (y >= 0) begin
                        x = x + ys;
                        y = y - xs;
                        z = z + STAGE_ANGLE[i];
                    end else begin
                        x = x - ys;
                        y = y + xs;
                        z = z - STAGE_ANGLE[i];
                    end
                end
                ux       = (x > 0) ? longint'(x) : 0;
                prod     = (ux >> 16) * GAIN_FIX + (((ux & 64'hFFFF) * GAIN_FIX) >> 16);
                dist_val = (prod + (64'd1 << 23)) >> 24;
            end
            a = (z - longint'(r.heading) * 256) % FINE_FULL;
            if (a < 0)
                a = a + FINE_FULL;
            b = (a + 128) / 256;
            if (b >= BEARING_FULL)
                b = b - BEARING_FULL;
            res.bearing  = b[bd_pkg::BEARING_W-1:0];
            res.distance = dist_val[bd_pkg::DIST_W-1:0];
            return res;
        endfunction

        function void note_input(t_pose_req r);
            expected_q.push_back(predict(r));
            accepted++;
        endfunction

        function void check_result(logic [bd_pkg::BEARING_W-1:0] bearing,
                                   logic [bd_pkg::DIST_W-1:0] distance);
            t_nav_result exp_r;
            if (expected_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: result with nothing expected: bearing %0d distance %0d",
                             $realtime, bearing, distance);
                return;
            end
            exp_r = expected_q.pop_front();
            checked++;
            if (bearing !== exp_r.bearing || distance !== exp_r.distance) begin
                errors++;
                if (errors <= 10)
                    $display("%0t: mismatch: bearing exp %0d got %0d, distance exp %0d got %0d",
                             $realtime, exp_r.bearing, bearing, exp_r.distance, distance);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    bit   idle_on;
    bit   hold_request;

    bd_in_if  req_if ();
    bd_out_if rsp_if ();

    bearing_and_distance dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    bearing_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #5_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // transfers on both channels, sampled at the rising edge
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1) begin
            if (req_if.valid && req_if.ready)
                sb.note_input({req_if.from_x, req_if.from_y, req_if.robot_heading,
                               req_if.to_x, req_if.to_y});
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.bearing, rsp_if.distance);
        end
    end

    // receiver: random stall bursts, plus one long hold on request
    initial begin : receiver
        int gap;
        rsp_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (i_rst_n !== 1'b1) begin
                rsp_if.ready = 1'b0;
            end else if (hold_request) begin
                rsp_if.ready = 1'b0;
                repeat (300) @(negedge i_clk);
                hold_request = 1'b0;
            end else if (idle_on && $urandom_range(0, 5) == 0) begin
                rsp_if.ready = 1'b0;
                gap = $urandom_range(1, 8);
                repeat (gap - 1) @(negedge i_clk);
            end else begin
                rsp_if.ready = 1'b1;
            end
        end
    end

    task automatic send_item(input t_pose_req it);
        int gap;
        @(negedge i_clk);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            req_if.valid = 1'b0;
            gap = $urandom_range(1, 8);
            repeat (gap) @(negedge i_clk);
        end
        req_if.valid         = 1'b1;
        req_if.from_x        = it.from_x;
        req_if.from_y        = it.from_y;
        req_if.robot_heading = it.heading;
        req_if.to_x          = it.to_x;
        req_if.to_y          = it.to_y;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic send_fields(input int fx, input int fy, input int hd, input int tx,
                               input int ty);
        t_pose_req it;
        it.from_x  = fx[bd_pkg::COORD_BITS-1:0];
        it.from_y  = fy[bd_pkg::COORD_BITS-1:0];
        it.heading = hd[bd_pkg::HD_W-1:0];
        it.to_x    = tx[bd_pkg::COORD_BITS-1:0];
        it.to_y    = ty[bd_pkg::COORD_BITS-1:0];
        send_item(it);
    endtask

    function automatic logic signed [bd_pkg::COORD_BITS-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic t_pose_req random_pose();
        t_pose_req it;
        int        mode;
        mode       = $urandom_range(0, 9);
        it.from_x  = bd_pkg::COORD_BITS'($urandom);
        it.from_y  = bd_pkg::COORD_BITS'($urandom);
        it.to_x    = bd_pkg::COORD_BITS'($urandom);
        it.to_y    = bd_pkg::COORD_BITS'($urandom);
        it.heading = bd_pkg::HD_W'(int'($urandom_range(0, 92160)) - 46080);
        case (mode)
            5: begin
                // same point
                it.to_x = it.from_x;
                it.to_y = it.from_y;
            end
            6: begin
                it.to_x = bd_pkg::COORD_BITS'(int'(it.from_x) + int'($urandom_range(0, 8)) - 4);
                it.to_y = bd_pkg::COORD_BITS'(int'(it.from_y) + int'($urandom_range(0, 8)) - 4);
            end
            7: begin
                if ($urandom_range(0, 1))
                    it.to_x = it.from_x;
                else
                    it.to_y = it.from_y;
            end
            8: begin
                it.from_x = corner_coord();
                it.from_y = corner_coord();
                it.to_x   = corner_coord();
                it.to_y   = corner_coord();
            end
            9: it.heading = bd_pkg::HD_W'($urandom);
            default: ;
        endcase
        return it;
    endfunction

    initial begin : stimulus
        i_rst_n              = 1'b0;
        idle_on              = 1'b0;
        hold_request         = 1'b0;
        req_if.valid         = 1'b0;
        req_if.from_x        = '0;
        req_if.from_y        = '0;
        req_if.robot_heading = '0;
        req_if.to_x          = '0;
        req_if.to_y          = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        idle_on = 1'b1;

        // equal points across heading extremes
        send_fields(0, 0, 0, 0, 0);
        send_fields(100, -200, 46080, 100, -200);
        send_fields(-32768, 32767, -46080, -32768, 32767);
        send_fields(5, 5, 65535, 5, 5);
        send_fields(7, -7, -65536, 7, -7);
        send_fields(0, 0, 1, 0, 0);
        // coordinate extremes and diagonals
        send_fields(-32768, -32768, 0, 32767, 32767);
        send_fields(32767, 32767, 0, -32768, -32768);
        send_fields(-32768, 32767, 11520, 32767, -32768);
        send_fields(32767, -32768, -11520, -32768, 32767);
        // axes, including straight behind
        send_fields(0, 0, 0, 1000, 0);
        send_fields(0, 0, 0, -1000, 0);
        send_fields(0, 0, 0, 0, 1000);
        send_fields(0, 0, 0, 0, -1000);
        send_fields(0, 0, 23040, 0, -32768);
        // left half plane on both sides, then unit and small offsets
        send_fields(0, 0, 0, 300, -400);
        send_fields(0, 0, 0, -300, -400);
        send_fields(0, 0, 0, 1, 1);
        send_fields(0, 0, 0, -1, -1);
        send_fields(10, 10, -1, 11, 10);
        send_fields(-1, -1, 32767, 0, 0);

        repeat (400) send_item(random_pose());

        // long output hold while inputs keep coming
        hold_request = 1'b1;
        repeat (60) send_item(random_pose());

        // pause until the pipeline drains
        @(negedge i_clk);
        req_if.valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);

        repeat (250) send_item(random_pose());

        // back-to-back tail with no idling
        idle_on = 1'b0;
        repeat (140) send_item(random_pose());
        @(negedge i_clk);
        req_if.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        $display("run: %0d pose/target transfers in, %0d results checked", sb.accepted,
                 sb.checked);
        $display("covered equal points, extreme coordinates and headings, a long output hold");
        if (sb.errors == 0 && sb.pending() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("%0d mismatches, %0d results missing", sb.errors, sb.pending());
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
